// ----- sv/aifp_pkg.sv -----
package aifp_pkg;

    // field parse phase
    typedef enum logic [1:0] {
        PH_SKIP     = 2'd0,
        PH_DIGITS   = 2'd1,
        PH_HEX_ZERO = 2'd2
    } phase_t;

    // per-character status
    typedef enum logic [2:0] {
        ST_CONTINUE  = 3'd0,
        ST_DONE_USED = 3'd1,
        ST_DONE_KEPT = 3'd2,
        ST_FAIL_USED = 3'd3,
        ST_FAIL_KEPT = 3'd4
    } status_t;

    // conversion codes
    localparam logic [1:0] CONV_SDEC = 2'd0;
    localparam logic [1:0] CONV_UDEC = 2'd1;
    localparam logic [1:0] CONV_OCT  = 2'd2;
    localparam logic [1:0] CONV_HEX  = 2'd3;

    // result size codes
    localparam logic [1:0] SIZE_SHORT = 2'd0;
    localparam logic [1:0] SIZE_INT   = 2'd1;

    // register indexes
    localparam logic [1:0] CFG_CONVERSION  = 2'd0;
    localparam logic [1:0] CFG_RESULT_SIZE = 2'd1;
    localparam logic [1:0] CFG_MAX_WIDTH   = 2'd2;

    localparam int CFG_DATA_BITS = 8;
    localparam int VALUE_BITS    = 64;

    // character codes
    localparam logic [7:0] CH_SPACE     = 8'd32;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_F   = 8'h46;
    localparam logic [7:0] CH_LOWER_X   = 8'h78;
    localparam logic [7:0] CH_UPPER_X   = 8'h58;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_CASE_BIT  = 8'h20;

    typedef struct packed {
        phase_t phase;
        logic   negative;
        logic   got_digit;
    } field_flags_t;

    typedef struct packed {
        logic [1:0] conversion;
        logic [1:0] result_size;
        logic [7:0] max_width;
    } cfg_t;

endpackage

// ----- sv/aifp_in_if.sv -----
interface aifp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_input;

    modport source (output valid, output char_in, output end_of_input, input ready);
    modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

// ----- sv/aifp_out_if.sv -----
interface aifp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink (input valid, input status, input value, output ready);
endinterface

// ----- sv/aifp_step.sv -----
module aifp_step
    import aifp_pkg::*;
#(
    parameter int ACC_BITS           = 64,
    parameter int WIDTH_COUNTER_BITS = 8
)
(
    input  logic [7:0]                    char_in,
    input  logic                          end_of_input,
    input  cfg_t                          cfg,
    input  field_flags_t                  flags,
    input  logic [ACC_BITS-1:0]           acc,
    input  logic [WIDTH_COUNTER_BITS-1:0] width_left,
    output field_flags_t                  flags_next,
    output logic [ACC_BITS-1:0]           acc_next,
    output logic [WIDTH_COUNTER_BITS-1:0] width_left_next,
    output status_t                       status,
    output logic [VALUE_BITS-1:0]         value
);

    localparam int WB = WIDTH_COUNTER_BITS;

    logic                  is_space;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [7:0]            upper;
    logic                  start;
    logic [ACC_BITS-1:0]   base_acc;
    logic [WB-1:0]         base_wl;
    logic                  base_neg;
    logic                  base_got;
    logic [ACC_BITS-1:0]   mac;
    logic [ACC_BITS-1:0]   shifted;
    logic [ACC_BITS-1:0]   dec_term;
    logic [16:0]           mw_ext;
    logic [16:0]           wl_limit;
    logic [WB-1:0]         wl_load;
    logic [WB-1:0]         wl_dec;
    logic                  width_used;
    logic                  use_width;
    logic                  finish;
    logic                  consumed;
    logic [ACC_BITS-1:0]   cand_acc;
    logic                  cand_neg;
    logic                  cand_got;
    logic [VALUE_BITS-1:0] signed_val;

    // character classes
    always_comb
    begin
        is_space = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
        upper    = char_in & ~CH_CASE_BIT;
        is_digit = 1'b0;
        digit    = '0;
        if (char_in >= CH_ZERO && char_in <= CH_NINE)
        begin
            digit    = 4'(char_in - CH_ZERO);
            is_digit = (cfg.conversion != CONV_OCT) || (char_in <= CH_SEVEN);
        end
        else if (cfg.conversion == CONV_HEX && upper >= CH_UPPER_A && upper <= CH_UPPER_F)
        begin
            digit    = 4'(upper - CH_UPPER_A + 8'd10);
            is_digit = 1'b1;
        end
    end

    // width limit saturated to the counter range
    always_comb
    begin
        mw_ext   = 17'(cfg.max_width);
        wl_limit = 17'((17'd1 << WB) - 17'd1);
        wl_load  = WB'((mw_ext > wl_limit) ? wl_limit : mw_ext);
    end

    // a new field starts on the first non-space character
    assign start    = !end_of_input && (flags.phase == PH_SKIP) && !is_space;
    assign base_acc = start ? '0 : acc;
    assign base_wl  = start ? wl_load : width_left;
    assign base_neg = start ? 1'b0 : flags.negative;
    assign base_got = start ? 1'b0 : flags.got_digit;
    assign wl_dec   = base_wl - WB'(1);

    // multiply by base and add digit
    always_comb
    begin
        case (cfg.conversion)
            CONV_OCT:  shifted = base_acc << 3;
            CONV_HEX:  shifted = base_acc << 4;
            default:   shifted = base_acc << 3;
        endcase
        dec_term = (cfg.conversion == CONV_SDEC || cfg.conversion == CONV_UDEC)
                   ? (base_acc << 1) : '0;
        mac = shifted + dec_term + ACC_BITS'(digit);
    end

    // field sequencing
    always_comb
    begin
        cand_acc  = base_acc;
        cand_neg  = base_neg;
        cand_got  = base_got;
        use_width = 1'b0;
        finish    = 1'b0;
        consumed  = 1'b0;
        flags_next.phase = flags.phase;
        if (end_of_input)
        begin
            finish = 1'b1;
        end
        else if (flags.phase == PH_SKIP && is_space)
        begin
            flags_next.phase = PH_SKIP;
        end
        else if (start && cfg.conversion == CONV_SDEC
                 && (char_in == CH_MINUS || char_in == CH_PLUS))
        begin
            cand_neg         = (char_in == CH_MINUS);
            flags_next.phase = PH_DIGITS;
            use_width        = 1'b1;
        end
        else if (start && cfg.conversion == CONV_HEX && char_in == CH_ZERO)
        begin
            cand_got         = 1'b1;
            flags_next.phase = PH_HEX_ZERO;
            use_width        = 1'b1;
        end
        else if (!start && flags.phase == PH_HEX_ZERO && cfg.conversion == CONV_HEX
                 && (char_in == CH_LOWER_X || char_in == CH_UPPER_X))
        begin
            flags_next.phase = PH_DIGITS;
            use_width        = 1'b1;
        end
        else if (is_digit)
        begin
            cand_acc         = mac;
            cand_got         = 1'b1;
            flags_next.phase = PH_DIGITS;
            use_width        = 1'b1;
        end
        else
        begin
            finish = 1'b1;
        end

        width_used = use_width && (base_wl != '0) && (wl_dec == '0);
        if (width_used)
        begin
            finish   = 1'b1;
            consumed = 1'b1;
        end

        flags_next.negative  = cand_neg;
        flags_next.got_digit = cand_got;
        acc_next             = cand_acc;
        width_left_next      = (use_width && base_wl != '0) ? wl_dec : base_wl;
        if (finish)
        begin
            flags_next.phase     = PH_SKIP;
            flags_next.negative  = 1'b0;
            flags_next.got_digit = 1'b0;
            acc_next             = '0;
            width_left_next      = '0;
        end
    end

    // status and final value
    always_comb
    begin
        if (!finish)
            status = ST_CONTINUE;
        else if (cand_got)
            status = consumed ? ST_DONE_USED : ST_DONE_KEPT;
        else
            status = consumed ? ST_FAIL_USED : ST_FAIL_KEPT;

        signed_val = cand_neg ? (VALUE_BITS'(0) - VALUE_BITS'(cand_acc))
                              : VALUE_BITS'(cand_acc);
        value = '0;
        if (finish && cand_got)
        begin
            case (cfg.result_size)
                SIZE_SHORT: value = VALUE_BITS'(signed_val[15:0]);
                SIZE_INT:   value = VALUE_BITS'(signed_val[31:0]);
                default:    value = signed_val;
            endcase
        end
    end

endmodule

// ----- sv/ascii_integer_field_parser.sv -----
// channel | dir | beat payload               | handshake
// in_ch   | in  | char_in[7:0], end_of_input | valid/ready
// out_ch  | out | status[2:0], value[63:0]   | valid/ready
// cfg     | in  | cfg_index[1:0], cfg_data   | cfg_we, no stall
//
// One character beat per cycle sustained while the output is not stalled; an input beat
// reaches its result beat through the input register, then the result register.
// The field state and result register update in the same cycle from one
// multiply-by-base-and-add on the accumulator.
// Reset clears the field state and the valid flags and returns the configuration to its defaults.
// A stalled output holds its beat; the input register keeps one beat behind it.
module ascii_integer_field_parser
    import aifp_pkg::*;
#(
    parameter int ACC_BITS           = 64,
    parameter int WIDTH_COUNTER_BITS = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    aifp_in_if.sink                  in_ch,
    aifp_out_if.source               out_ch
);

    cfg_t                          cfg_reg;
    logic                          in_valid_reg;
    logic [7:0]                    in_char_reg;
    logic                          in_eoi_reg;
    field_flags_t                  flags_reg;
    field_flags_t                  flags_next;
    logic [ACC_BITS-1:0]           acc_reg;
    logic [ACC_BITS-1:0]           acc_next;
    logic [WIDTH_COUNTER_BITS-1:0] width_left_reg;
    logic [WIDTH_COUNTER_BITS-1:0] width_left_next;
    logic                          out_valid_reg;
    status_t                       status_reg;
    status_t                       status_next;
    logic [VALUE_BITS-1:0]         value_reg;
    logic [VALUE_BITS-1:0]         value_next;
    logic                          advance;
    logic                          in_take;

    // handshake
    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;
    assign in_take      = in_ch.valid && in_ch.ready;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = status_reg;
    assign out_ch.value  = value_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conversion  <= CONV_SDEC;
            cfg_reg.result_size <= SIZE_INT;
            cfg_reg.max_width   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONVERSION:  cfg_reg.conversion  <= cfg_data[1:0];
                CFG_RESULT_SIZE: cfg_reg.result_size <= cfg_data[1:0];
                CFG_MAX_WIDTH:   cfg_reg.max_width   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    aifp_step #(
        .ACC_BITS           (ACC_BITS),
        .WIDTH_COUNTER_BITS (WIDTH_COUNTER_BITS)
    ) u_step (
        .char_in         (in_char_reg),
        .end_of_input    (in_eoi_reg),
        .cfg             (cfg_reg),
        .flags           (flags_reg),
        .acc             (acc_reg),
        .width_left      (width_left_reg),
        .flags_next      (flags_next),
        .acc_next        (acc_next),
        .width_left_next (width_left_next),
        .status          (status_next),
        .value           (value_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= in_ch.char_in;
            in_eoi_reg  <= in_ch.end_of_input;
        end
    end

    // field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.phase     <= PH_SKIP;
            flags_reg.negative  <= 1'b0;
            flags_reg.got_digit <= 1'b0;
            acc_reg             <= '0;
            width_left_reg      <= '0;
        end
        else if (advance)
        begin
            flags_reg      <= flags_next;
            acc_reg        <= acc_next;
            width_left_reg <= width_left_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

endmodule

// ----- sv/aifp_checker.sv -----
module aifp_checker
    import aifp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  out_status,
    input logic [63:0] out_value
);

    // a stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // no stall upstream while the result side is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // status code range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status <= ST_FAIL_KEPT))
        else $error("status code out of range");

    // value only carries data on a completed field
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == ST_CONTINUE || out_status == ST_FAIL_USED
                      || out_status == ST_FAIL_KEPT) |-> (out_value == '0))
        else $error("value nonzero without a completed field");

endmodule

bind ascii_integer_field_parser aifp_checker u_aifp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_value  (out_ch.value)
);

// ----- sim/tb_ascii_integer_field_parser.sv -----
module tb_ascii_integer_field_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import aifp_pkg::*;

    localparam int DEC_RADIX = 10;
    localparam int OCT_RADIX = 8;
    localparam int HEX_RADIX = 16;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_WIDE = 2'd3;
    localparam int SEGMENTS = 9;
    localparam int SEGMENT_BEATS = 66;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } char_beat_t;

    typedef struct {
        status_t     status;
        logic [63:0] value;
    } field_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [1:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    aifp_in_if  in_ch();
    aifp_out_if out_ch();

    ascii_integer_field_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // character beats waiting to be sent, parse results waiting to arrive
    char_beat_t    char_stream[$];
    field_result_t pending_results[$];
    char_beat_t    next_beat;
    field_result_t want;
    int            mismatches = 0;
    int            send_idle_pct;
    int            recv_idle_pct;
    logic [1:0]    conv_cycle [4];
    logic [1:0]    size_cycle [4];

    // shadow of the configuration registers
    logic [1:0] conv_reg      = CONV_SDEC;
    logic [1:0] size_reg      = SIZE_INT;
    logic [7:0] max_width_reg = 8'd0;

    // shadow of the field state
    phase_t      fld_phase      = PH_SKIP;
    logic [7:0]  fld_width_left = 8'd0;
    logic [63:0] fld_acc        = 64'd0;
    logic        fld_negative   = 1'b0;
    logic        fld_got_digit  = 1'b0;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic bit is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic int conv_radix();
        if (conv_reg == CONV_OCT)
            return OCT_RADIX;
        if (conv_reg == CONV_HEX)
            return HEX_RADIX;
        return DEC_RADIX;
    endfunction

    // digit value in the current conversion, -1 when not a digit
    function automatic int digit_value(input logic [7:0] ch);
        logic [7:0] up;
        up = ch & ~CH_CASE_BIT;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            if (conv_reg == CONV_OCT && ch > CH_SEVEN)
                return -1;
            return int'(ch - CH_ZERO);
        end
        if (conv_reg == CONV_HEX && up >= CH_UPPER_A && up <= CH_UPPER_F)
            return int'(up - CH_UPPER_A) + DEC_RADIX;
        return -1;
    endfunction

    task automatic clear_field();
        fld_phase      = PH_SKIP;
        fld_width_left = 8'd0;
        fld_acc        = 64'd0;
        fld_negative   = 1'b0;
        fld_got_digit  = 1'b0;
    endtask

    // end of field: sign, size truncation, then back to skipping
    task automatic close_field(input bit consumed, output status_t st, output logic [63:0] val);
        logic [63:0] v;
        if (fld_got_digit)
        begin
            v = fld_negative ? 64'd0 - fld_acc : fld_acc;
            if (size_reg == SIZE_SHORT)
                v = {48'd0, v[15:0]};
            else if (size_reg == SIZE_INT)
                v = {32'd0, v[31:0]};
            val = v;
            st = consumed ? ST_DONE_USED : ST_DONE_KEPT;
        end
        else
        begin
            val = 64'd0;
            st = consumed ? ST_FAIL_USED : ST_FAIL_KEPT;
        end
        clear_field();
    endtask

    // one field character used; the last allowed position ends the field
    task automatic close_if_full(output status_t st, output logic [63:0] val);
        st = ST_CONTINUE;
        val = 64'd0;
        if (fld_width_left != 8'd0)
        begin
            fld_width_left = fld_width_left - 8'd1;
            if (fld_width_left == 8'd0)
                close_field(1'b1, st, val);
        end
    endtask

    task automatic take_digit(input logic [7:0] ch, output status_t st, output logic [63:0] val);
        int d;
        d = digit_value(ch);
        if (d < 0)
        begin
            close_field(1'b0, st, val);
        end
        else
        begin
            fld_acc = fld_acc * conv_radix() + 64'(d);
            fld_got_digit = 1'b1;
            fld_phase = PH_DIGITS;
            close_if_full(st, val);
        end
    endtask

    // expected status and value for one accepted character beat
    task automatic parse_step(input logic [7:0] ch, input logic eoi);
        status_t       st;
        logic [63:0]   val;
        field_result_t res;
        st = ST_CONTINUE;
        val = 64'd0;
        if (eoi)
        begin
            close_field(1'b0, st, val);
        end
        else if (fld_phase == PH_SKIP)
        begin
            if (!is_blank(ch))
            begin
                clear_field();
                fld_width_left = max_width_reg;
                if (conv_reg == CONV_SDEC && (ch == CH_MINUS || ch == CH_PLUS))
                begin
                    fld_negative = (ch == CH_MINUS);
                    fld_phase = PH_DIGITS;
                    close_if_full(st, val);
                end
                else if (conv_reg == CONV_HEX && ch == CH_ZERO)
                begin
                    fld_got_digit = 1'b1;
                    fld_phase = PH_HEX_ZERO;
                    close_if_full(st, val);
                end
                else
                begin
                    take_digit(ch, st, val);
                end
            end
        end
        else if (fld_phase == PH_HEX_ZERO && conv_reg == CONV_HEX &&
                 (ch == CH_LOWER_X || ch == CH_UPPER_X))
        begin
            fld_phase = PH_DIGITS;
            close_if_full(st, val);
        end
        else
        begin
            take_digit(ch, st, val);
        end
        res.status = st;
        res.value = val;
        pending_results.push_back(res);
    endtask

    // stimulus helpers
    task automatic push_char(input logic [7:0] c);
        char_beat_t b;
        b.ch = c;
        b.eoi = 1'b0;
        char_stream.push_back(b);
    endtask

    task automatic push_eoi();
        char_beat_t b;
        b.ch = 8'($urandom_range(0, 255));
        b.eoi = 1'b1;
        char_stream.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < DEC_RADIX)
            return CH_ZERO + 8'(d);
        return (CH_UPPER_A + 8'(d - DEC_RADIX)) | ($urandom_range(0, 1) ? CH_CASE_BIT : 8'h00);
    endfunction

    // one field: mostly well formed with random content, some noise and broken ones
    task automatic gen_field();
        int kind;
        int n_dig;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                if ($urandom_range(0, 7) == 0)
                    push_eoi();
                else
                    push_char(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                push_char(blank_char());
            if (conv_reg == CONV_SDEC ? $urandom_range(0, 1) == 1 : $urandom_range(0, 9) == 0)
                push_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            if (conv_reg == CONV_HEX && $urandom_range(0, 1) == 1)
            begin
                push_char(CH_ZERO);
                if ($urandom_range(0, 3) != 0)
                    push_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
            end
            n_dig = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
            for (int i = 0; i < n_dig; i++)
            begin
                // broken field: a stray character in the middle of the digits
                if (kind == 1 && i == n_dig / 2)
                    push_char(8'($urandom_range(0, 255)));
                push_char(digit_char($urandom_range(0, conv_radix() - 1)));
            end
            case ($urandom_range(0, 3))
                0: push_eoi();
                1: push_char(blank_char());
                2: push_char(8'($urandom_range(0, 255)));
                default: ;
            endcase
        end
    endtask

    // register write, shadow updated once the block has taken it
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_CONVERSION)
            conv_reg = data[1:0];
        else if (idx == CFG_RESULT_SIZE)
            size_reg = data[1:0];
        else if (idx == CFG_MAX_WIDTH)
            max_width_reg = data[7:0];
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (char_stream.size() != 0 || in_ch.valid || pending_results.size() != 0);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                parse_step(in_ch.char_in, in_ch.end_of_input);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (char_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_beat = char_stream.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.char_in <= next_beat.ch;
                    in_ch.end_of_input <= next_beat.eoi;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat status %0d value %h",
                             $time, out_ch.status, out_ch.value);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $time, want.value, out_ch.value);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // stimulus sequence
    initial
    begin
        logic [7:0] width_val;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CONVERSION;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.char_in = 8'd0;
        in_ch.end_of_input = 1'b0;
        out_ch.ready = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 48;
        conv_cycle = '{CONV_SDEC, CONV_UDEC, CONV_OCT, CONV_HEX};
        size_cycle = '{SIZE_SHORT, SIZE_INT, SIZE_LONG, SIZE_WIDE};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: signed decimal, 32 bits, no width limit
        push_text(" \t-12");
        push_eoi();
        push_text("+7x");
        push_char(8'hFF);
        push_char(8'h00);

        // hex with prefix, lone 0x, 16 bit truncation
        wait_idle();
        write_reg(CFG_CONVERSION, {6'd0, CONV_HEX});
        write_reg(CFG_RESULT_SIZE, {6'd0, SIZE_SHORT});
        write_reg(CFG_MAX_WIDTH, 8'd0);
        push_text("0x");
        push_eoi();
        push_text("0XfF1g");

        // octal rejects 8, width of two ends the field, size code 3 with pad bits
        wait_idle();
        write_reg(CFG_CONVERSION, {6'h3F, CONV_OCT});
        write_reg(CFG_RESULT_SIZE, {6'h3F, SIZE_WIDE});
        write_reg(CFG_MAX_WIDTH, 8'd2);
        push_text("78123");

        // open field carried into unsigned mode, sign rejected, width of one
        wait_idle();
        write_reg(CFG_CONVERSION, {6'd0, CONV_UDEC});
        write_reg(CFG_RESULT_SIZE, {6'd0, SIZE_LONG});
        write_reg(CFG_MAX_WIDTH, 8'd1);
        push_text("-9 ");
        push_eoi();

        // random fields, one setting and idle mix per segment
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            send_idle_pct = (seg < 3) ? 13 : (seg < 6) ? 48 : 0;
            recv_idle_pct = (seg < 3) ? 48 : (seg < 6) ? 13 : 0;
            write_reg(CFG_CONVERSION, {6'($urandom_range(0, 63)), conv_cycle[seg % 4]});
            write_reg(CFG_RESULT_SIZE,
                      {6'($urandom_range(0, 63)), size_cycle[(seg + seg / 4) % 4]});
            if (seg == 0)
                width_val = 8'd0;
            else if (seg == 1)
                width_val = 8'd255;
            else
            begin
                case ($urandom_range(0, 3))
                    0: width_val = 8'd0;
                    1: width_val = 8'($urandom_range(1, 4));
                    2: width_val = 8'($urandom_range(5, 20));
                    default: width_val = 8'($urandom_range(0, 255));
                endcase
            end
            write_reg(CFG_MAX_WIDTH, width_val);
            while (char_stream.size() < SEGMENT_BEATS)
                gen_field();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ascii_integer_field_parser] OK");
        else
            $display("[ascii_integer_field_parser] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("[ascii_integer_field_parser] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/aifp_pkg.sv
sv/aifp_in_if.sv
sv/aifp_out_if.sv
sv/aifp_step.sv
sv/ascii_integer_field_parser.sv
sv/aifp_checker.sv
sim/tb_ascii_integer_field_parser.sv
